FILE: design/nue_pkg.sv
`default_nettype none

package nue_pkg;

	localparam int MaxResults = 4;
	localparam int CntW = $clog2(MaxResults + 1);
	localparam int IdxW = $clog2(MaxResults);

	localparam logic [7:0] EscByte = 8'h03;
	localparam logic [7:0] ZeroByte = 8'h00;

	localparam logic DirRemove = 1'b0;
	localparam logic DirInsert = 1'b1;

	localparam logic KindData = 1'b0;
	localparam logic KindHeader = 1'b1;

	localparam logic [1:0] HdrNone = 2'd0;
	localparam logic [1:0] HdrOne = 2'd1;
	localparam logic [1:0] HdrDone = 2'd2;

	localparam logic [1:0] RunMax = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
		logic       last;
		logic [5:0] nal_type;
		logic [5:0] layer_id;
		logic [2:0] temporal_id;
	} nue_in_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic [5:0] hdr_type;
		logic [5:0] hdr_layer;
		logic [2:0] hdr_temporal;
		logic       header_error;
		logic       end_of_unit;
	} nue_out_t;

	typedef struct packed {
		logic [1:0] zero_run;
		logic [1:0] header_count;
		logic [7:0] first_header_byte;
	} nue_state_t;

endpackage

`default_nettype wire

FILE: design/nue_step.sv
`default_nettype none

module nue_step (
	input  wire logic                   dir,
	input  wire nue_pkg::nue_state_t    state,
	input  wire nue_pkg::nue_in_t       item,
	output nue_pkg::nue_out_t           res [nue_pkg::MaxResults],
	output logic [nue_pkg::CntW-1:0]    cnt,
	output nue_pkg::nue_state_t         state_next
);

	function automatic logic [1:0] run_after(input logic [1:0] run, input logic [7:0] b);
		logic [1:0] r;
		begin
			if (b == nue_pkg::ZeroByte) begin
				r = (run < nue_pkg::RunMax) ? run + 2'd1 : run;
			end else begin
				r = 2'd0;
			end
			return r;
		end
	endfunction

	always_comb begin
		nue_pkg::nue_state_t st;
		logic [nue_pkg::CntW-1:0] n;
		logic [7:0] b;
		logic [7:0] fb;
		logic [2:0] tfield;
		logic tail;
		st = state;
		n = '0;
		b = item.data_byte;
		fb = state.first_header_byte;
		tfield = b[2:0];
		tail = item.last && (b == nue_pkg::ZeroByte);
		for (int i = 0; i < nue_pkg::MaxResults; i++) begin
			res[i] = '0;
		end
		if (item.first) begin
			st.header_count = nue_pkg::HdrNone;
			st.zero_run = 2'd0;
		end
		if (dir == nue_pkg::DirRemove) begin
			if (st.header_count == nue_pkg::HdrNone) begin
				st.first_header_byte = b;
				st.header_count = nue_pkg::HdrOne;
				if (item.last) begin
					res[0].kind = nue_pkg::KindHeader;
					res[0].hdr_type = b[6:1];
					res[0].hdr_layer = {b[0], 5'd0};
					res[0].header_error = 1'b1;
					res[0].end_of_unit = 1'b1;
					n = nue_pkg::CntW'(1);
				end
			end else if (st.header_count == nue_pkg::HdrOne) begin
				res[0].kind = nue_pkg::KindHeader;
				res[0].hdr_type = fb[6:1];
				res[0].hdr_layer = {fb[0], b[7:3]};
				res[0].hdr_temporal = (tfield == 3'd0) ? 3'd0 : tfield - 3'd1;
				res[0].header_error = fb[7] || (tfield == 3'd0);
				res[0].end_of_unit = item.last;
				n = nue_pkg::CntW'(1);
				st.header_count = nue_pkg::HdrDone;
				st.zero_run = 2'd0;
			end else begin
				if (st.zero_run == nue_pkg::RunMax && b == nue_pkg::EscByte) begin
					st.zero_run = 2'd0;
				end else begin
					res[0].kind = nue_pkg::KindData;
					res[0].out_byte = b;
					res[0].end_of_unit = item.last;
					n = nue_pkg::CntW'(1);
					st.zero_run = run_after(st.zero_run, b);
				end
			end
		end else begin
			if (st.header_count != nue_pkg::HdrDone) begin
				res[0].out_byte = {item.nal_type, item.layer_id[5]};
				res[1].out_byte = {item.layer_id[4:0], 3'(item.temporal_id + 3'd1)};
				n = nue_pkg::CntW'(2);
				st.header_count = nue_pkg::HdrDone;
				st.zero_run = 2'd0;
			end
			if (st.zero_run == nue_pkg::RunMax && b[7:2] == 6'd0) begin
				res[n[nue_pkg::IdxW-1:0]].out_byte = nue_pkg::EscByte;
				n = n + 1'b1;
				st.zero_run = 2'd0;
			end
			res[n[nue_pkg::IdxW-1:0]].out_byte = b;
			res[n[nue_pkg::IdxW-1:0]].end_of_unit = item.last && !tail;
			n = n + 1'b1;
			st.zero_run = run_after(st.zero_run, b);
			if (tail) begin
				res[n[nue_pkg::IdxW-1:0]].out_byte = nue_pkg::EscByte;
				res[n[nue_pkg::IdxW-1:0]].end_of_unit = 1'b1;
				n = n + 1'b1;
			end
		end
		if (item.last) begin
			st.header_count = nue_pkg::HdrNone;
			st.zero_run = 2'd0;
		end
		cnt = n;
		state_next = st;
	end

endmodule

`default_nettype wire

FILE: design/nal_unit_emulation_prevention.sv
// channel   | direction | signals                          | transfer when
// item      | in        | item_valid, item_stall, item     | item_valid && !item_stall
// result    | out       | result_valid, result_stall, result | result_valid && !result_stall
// cfg       | in        | cfg_valid, cfg_ready, cfg_data   | cfg_valid && cfg_ready
//
// an item stays in the input register until its results (0..4) have all gone to the result register
// unless stalled, one result per cycle goes out via the result register, fed by the input register
// one-result items stream at one per cycle if unstalled; inserted escapes and headers stall input
// arst_n clears direction, zero run, header count and all valid flags
// result_stall holds the result register and, through it, the input register if results remain

`default_nettype none

module nal_unit_emulation_prevention (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire nue_pkg::nue_in_t    item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output nue_pkg::nue_out_t        result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_data
);

	logic                      dir_q;
	nue_pkg::nue_state_t       state_q;
	nue_pkg::nue_state_t       state_next;
	nue_pkg::nue_in_t          item_s1;
	logic                      valid_s1;
	logic [nue_pkg::IdxW-1:0]  idx_q;
	nue_pkg::nue_out_t         res [nue_pkg::MaxResults];
	logic [nue_pkg::CntW-1:0]  cnt;
	nue_pkg::nue_out_t         result_s2;
	logic                      valid_s2;
	logic                      out_free;
	logic                      emit;
	logic                      last_res;
	logic                      done;
	logic                      accept;

	nue_step u_step (
		.dir        (dir_q),
		.state      (state_q),
		.item       (item_s1),
		.res        (res),
		.cnt        (cnt),
		.state_next (state_next)
	);

	assign out_free = !valid_s2 || !result_stall;
	assign last_res = ({1'b0, idx_q} + nue_pkg::CntW'(1)) == cnt;
	assign emit = valid_s1 && (cnt != '0) && out_free;
	assign done = valid_s1 && ((cnt == '0) || (out_free && last_res));
	assign item_stall = valid_s1 && !done;
	assign accept = item_valid && !item_stall;
	assign cfg_ready = 1'b1;
	assign result_valid = valid_s2;
	assign result = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= nue_pkg::DirRemove;
			state_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dir_q <= cfg_data;
			end
			if (done) begin
				state_q <= state_next;
				idx_q <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			valid_s1 <= accept || (valid_s1 && !done);
			valid_s2 <= emit || (valid_s2 && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (emit) begin
			result_s2 <= res[idx_q];
		end
	end

endmodule

`default_nettype wire

FILE: design/nue_check.sv
`default_nettype none

module nue_check (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_stall,
	input wire nue_pkg::nue_in_t  item,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire nue_pkg::nue_out_t result
);

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// stalled input holds
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("input changed while stalled");

	// input stall with an empty output must produce a result next cycle
	a_stall_progress: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall && !result_valid |=> result_valid)
		else $error("input stalled without output progress");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == nue_pkg::KindData |->
			result.hdr_type == 6'd0 && result.hdr_layer == 6'd0 &&
			result.hdr_temporal == 3'd0 && !result.header_error)
		else $error("data result carries header fields");

	a_hdr_temporal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == nue_pkg::KindHeader |-> result.hdr_temporal != 3'd7)
		else $error("temporal id out of range");

endmodule

bind nal_unit_emulation_prevention nue_check u_nue_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
